@@ design/lsbde_pkg.sv @@
// Shared types and constants for the LED strip bit duty encoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lsbde_pkg;

    // Fixed sizes of the block
    localparam int MAX_COLORS  = 4;
    localparam int DUTY_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int COLOR_CNT_W = 3;
    localparam int SLOT_W      = 2;
    localparam int CHAN_W      = $clog2(MAX_COLORS);
    localparam int BITS_W      = MAX_COLORS * BYTE_W;
    localparam int WORD_CNT_W  = $clog2(BITS_W);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_COLORS  = 4'd0,
        REG_COLOR_SLOT0 = 4'd1,
        REG_COLOR_SLOT1 = 4'd2,
        REG_COLOR_SLOT2 = 4'd3,
        REG_COLOR_SLOT3 = 4'd4,
        REG_PERIOD      = 4'd5,
        REG_SHORT_HIGH  = 4'd6,
        REG_LONG_HIGH   = 4'd7
    } cfg_reg_t;

    // Color slot sources
    typedef enum logic [SLOT_W-1:0] {
        SLOT_RED   = 2'd0,
        SLOT_GREEN = 2'd1,
        SLOT_BLUE  = 2'd2,
        SLOT_WHITE = 2'd3
    } slot_t;

    // Input item modes
    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_RAW   = 1'b1
    } mode_t;

    // Register file contents seen by the datapath
    typedef struct packed {
        logic [COLOR_CNT_W-1:0]         color_count;
        logic [MAX_COLORS-1:0][SLOT_W-1:0] color_slot;
        logic [DUTY_W-1:0]              period_cycles;
        logic [DUTY_W-1:0]              short_high_cycles;
        logic [DUTY_W-1:0]              long_high_cycles;
    } cfg_t;

    // One classified item waiting for the serializer: channel bytes packed
    // first byte in the top bits, and the number of duty words minus one.
    typedef struct packed {
        logic [BITS_W-1:0]     bits;
        logic [WORD_CNT_W-1:0] words_m1;
        logic                  last_item;
    } job_t;

endpackage

@@ design/lsbde_item_if.sv @@
// Input item channel: one pixel or one raw channel byte per transaction.
// Depends on lsbde_pkg.
`timescale 1ns / 1ps

interface lsbde_item_if;
    import lsbde_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] channel_byte;
    logic              last_item;

    modport source (output valid, mode, red, green, blue, channel_byte, last_item,
                    input ready);
    modport sink   (input valid, mode, red, green, blue, channel_byte, last_item,
                    output ready);
endinterface

@@ design/lsbde_duty_if.sv @@
// Result channel: one PWM duty word per transaction.
// Depends on lsbde_pkg.
`timescale 1ns / 1ps

interface lsbde_duty_if;
    import lsbde_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_cycles;
    logic              last_of_item;
    logic              end_of_frame;

    modport source (output valid, duty_cycles, last_of_item, end_of_frame,
                    input ready);
    modport sink   (input valid, duty_cycles, last_of_item, end_of_frame,
                    output ready);
endinterface

@@ design/lsbde_cfg_if.sv @@
// Configuration write channel: register index and write data per transaction.
// Depends on lsbde_pkg.
`timescale 1ns / 1ps

interface lsbde_cfg_if;
    import lsbde_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/lsbde_cfg_regs.sv @@
// Configuration register file of the encoder.
// Depends on lsbde_pkg and lsbde_cfg_if.
`timescale 1ns / 1ps

module lsbde_cfg_regs
    import lsbde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lsbde_cfg_if.sink   cfg,
    output cfg_t        regs
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    // Decode one write transaction
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_NUM_COLORS:  cfg_next.color_count = cfg.data[COLOR_CNT_W-1:0];
                REG_COLOR_SLOT0: cfg_next.color_slot[0] = cfg.data[SLOT_W-1:0];
                REG_COLOR_SLOT1: cfg_next.color_slot[1] = cfg.data[SLOT_W-1:0];
                REG_COLOR_SLOT2: cfg_next.color_slot[2] = cfg.data[SLOT_W-1:0];
                REG_COLOR_SLOT3: cfg_next.color_slot[3] = cfg.data[SLOT_W-1:0];
                REG_PERIOD:      cfg_next.period_cycles = cfg.data[DUTY_W-1:0];
                REG_SHORT_HIGH:  cfg_next.short_high_cycles = cfg.data[DUTY_W-1:0];
                REG_LONG_HIGH:   cfg_next.long_high_cycles = cfg.data[DUTY_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_count       <= COLOR_CNT_W'(3);
            cfg_reg.color_slot[0]     <= SLOT_GREEN;
            cfg_reg.color_slot[1]     <= SLOT_RED;
            cfg_reg.color_slot[2]     <= SLOT_BLUE;
            cfg_reg.color_slot[3]     <= SLOT_WHITE;
            cfg_reg.period_cycles     <= DUTY_W'(80);
            cfg_reg.short_high_cycles <= DUTY_W'(22);
            cfg_reg.long_high_cycles  <= DUTY_W'(44);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/lsbde_front.sv @@
// Front end: accepts input items and turns them into serializer jobs
// (channel byte mapping and word count). Depends on lsbde_pkg, lsbde_item_if.
`timescale 1ns / 1ps

module lsbde_front
    import lsbde_pkg::*;
(
    lsbde_item_if.sink  pixel,
    input  cfg_t        regs,
    input  logic        job_ready,
    output logic        job_valid,
    output job_t        job
);

    logic [CHAN_W-1:0] nbytes_m1;

    // Handshake passes straight to the queue
    assign job_valid   = pixel.valid;
    assign pixel.ready = job_ready;

    // Channel count with out-of-range values folded in
    always_comb
    begin
        if (regs.color_count == '0)
            nbytes_m1 = '0;
        else if (regs.color_count >= COLOR_CNT_W'(MAX_COLORS))
            nbytes_m1 = CHAN_W'(MAX_COLORS - 1);
        else
            nbytes_m1 = CHAN_W'(regs.color_count - COLOR_CNT_W'(1));
    end

    // Byte mapping per slot, first byte on top
    always_comb
    begin
        job.bits      = '0;
        job.last_item = pixel.last_item;
        if (pixel.mode == MODE_RAW)
        begin
            job.bits[BITS_W-1 -: BYTE_W] = pixel.channel_byte;
            job.words_m1 = WORD_CNT_W'(BYTE_W - 1);
        end
        else
        begin
            for (int c = 0; c < MAX_COLORS; c++)
            begin
                case (regs.color_slot[c])
                    SLOT_RED:   job.bits[BITS_W-1-c*BYTE_W -: BYTE_W] = pixel.red;
                    SLOT_GREEN: job.bits[BITS_W-1-c*BYTE_W -: BYTE_W] = pixel.green;
                    SLOT_BLUE:  job.bits[BITS_W-1-c*BYTE_W -: BYTE_W] = pixel.blue;
                    default:    job.bits[BITS_W-1-c*BYTE_W -: BYTE_W] = '0;
                endcase
            end
            job.words_m1 = {nbytes_m1, 3'b111};
        end
    end

endmodule

@@ design/lsbde_queue.sv @@
// Two-entry job queue between front end and serializer.
// Depends on lsbde_pkg.
`timescale 1ns / 1ps

module lsbde_queue
    import lsbde_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  job_t  push_job,
    output logic  pop_valid,
    input  logic  pop_ready,
    output job_t  pop_job
);

    job_t       mem [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = mem[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wptr_next  = do_push ? ~wptr_reg : wptr_reg;
        rptr_next  = do_pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!do_push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wptr_reg] <= push_job;
    end

endmodule

@@ design/lsbde_back.sv @@
// Back end: shifts job bits out MSB first, one duty word per unstalled
// cycle, with duty clamp and end markers. Needs lsbde_pkg, lsbde_duty_if.
`timescale 1ns / 1ps

module lsbde_back
    import lsbde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        regs,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    lsbde_duty_if.source duty
);

    logic                  busy_reg, busy_next;
    logic [BITS_W-1:0]     shift_reg, shift_next;
    logic [WORD_CNT_W-1:0] left_reg, left_next;
    logic                  frame_reg, frame_next;
    logic                  ovalid_reg, ovalid_next;
    logic [DUTY_W-1:0]     oduty_reg, oduty_next;
    logic                  olast_reg, olast_next;
    logic                  oeof_reg, oeof_next;

    logic                  can_emit;
    logic                  last_word;
    logic [DUTY_W-1:0]     per;
    logic [DUTY_W-1:0]     high;
    logic [DUTY_W-1:0]     clamped;

    assign duty.valid        = ovalid_reg;
    assign duty.duty_cycles  = oduty_reg;
    assign duty.last_of_item = olast_reg;
    assign duty.end_of_frame = oeof_reg;

    assign can_emit  = !ovalid_reg || duty.ready;
    assign last_word = (left_reg == '0);

    // Duty clamp to 1..period-1 for the current bit (period at least 2)
    always_comb
    begin
        per  = (regs.period_cycles < DUTY_W'(2)) ? DUTY_W'(2) : regs.period_cycles;
        high = shift_reg[BITS_W-1] ? regs.long_high_cycles : regs.short_high_cycles;
        clamped = (high == '0) ? DUTY_W'(1) : high;
        if (clamped >= per)
            clamped = per - DUTY_W'(1);
    end

    // Serializer control and output register
    always_comb
    begin
        busy_next   = busy_reg;
        shift_next  = shift_reg;
        left_next   = left_reg;
        frame_next  = frame_reg;
        ovalid_next = ovalid_reg && !duty.ready;
        oduty_next  = oduty_reg;
        olast_next  = olast_reg;
        oeof_next   = oeof_reg;
        job_ready   = 1'b0;

        if (busy_reg && can_emit)
        begin
            ovalid_next = 1'b1;
            oduty_next  = clamped;
            olast_next  = last_word;
            oeof_next   = last_word && frame_reg;
            shift_next  = {shift_reg[BITS_W-2:0], 1'b0};
            left_next   = left_reg - WORD_CNT_W'(1);
            if (last_word)
            begin
                // Chain straight into the next job
                job_ready = 1'b1;
                busy_next = job_valid;
            end
        end
        else if (!busy_reg)
        begin
            job_ready = 1'b1;
            busy_next = job_valid;
        end

        if (job_ready && job_valid)
        begin
            shift_next = job.bits;
            left_next  = job.words_m1;
            frame_next = job.last_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        left_reg  <= left_next;
        frame_reg <= frame_next;
        oduty_reg <= oduty_next;
        olast_reg <= olast_next;
        oeof_reg  <= oeof_next;
    end

endmodule

@@ design/led_strip_bit_duty_encoder.sv @@
// Top level of the LED strip bit duty encoder.
// Depends on lsbde_pkg, the channel interfaces and all lsbde_* modules.
`timescale 1ns / 1ps

// Each pixel (mode 0) expands to as many channel bytes as the color count
// register gives (0 counts as 1, above 4 as 4), picked by the color slot
// registers, each raw item (mode 1) to one byte; every byte then leaves as
// eight duty words, MSB first, one word per clock while the duty sink is
// ready, emitted by the back-end shift register. Items pass through a
// two-entry queue, so the next item is taken while the current one is still
// being sent. Configuration writes are accepted every cycle and must only
// be made while no item is in flight.

module led_strip_bit_duty_encoder
    import lsbde_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lsbde_cfg_if.sink    cfg,
    lsbde_item_if.sink   pixel,
    lsbde_duty_if.source duty
);

    cfg_t regs;
    logic push_valid, push_ready;
    job_t push_job;
    logic pop_valid, pop_ready;
    job_t pop_job;

    lsbde_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    lsbde_front u_front (
        .pixel     (pixel),
        .regs      (regs),
        .job_ready (push_ready),
        .job_valid (push_valid),
        .job       (push_job)
    );

    lsbde_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    lsbde_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .duty      (duty)
    );

endmodule
